### hdl/mtf_pkg.sv
// Shared types and constants for the meter telegram framer.
`timescale 1ns / 1ps
`default_nettype none

package mtf_pkg;

  // Widths of the word fields on both channels.
  localparam int BYTE_W  = 8;
  localparam int FIELD_W = 11;
  localparam int EVENT_W = 3;

  // Characters that drive the framing.
  localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CHAR_BANG  = 8'h21;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

  // Register index on the configuration port.
  localparam logic REG_CHECKSUM_EN = 1'b0;

  // Event code reported with every result word.
  typedef enum logic [EVENT_W-1:0] {
    EV_DROP     = 3'd0,
    EV_STORE    = 3'd1,
    EV_DONE     = 3'd2,
    EV_RESYNC   = 3'd3,
    EV_OVF_DROP = 3'd4
  } event_t;

  // True for 0-9, A-F and a-f.
  function automatic logic is_hex(input logic [BYTE_W-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

endpackage

`default_nettype wire

### hdl/mtf_in_if.sv
// Valid/ready channel carrying one received byte per word.
`timescale 1ns / 1ps
`default_nettype none

interface mtf_in_if;
  import mtf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hdl/mtf_out_if.sv
// Valid/ready channel carrying one framing result per word.
`timescale 1ns / 1ps
`default_nettype none

interface mtf_out_if;
  import mtf_pkg::*;

  logic               valid;
  logic               ready;
  logic [EVENT_W-1:0] event_res;
  logic [BYTE_W-1:0]  byte_out;
  logic [FIELD_W-1:0] write_addr;
  logic [FIELD_W-1:0] base_addr;
  logic [FIELD_W-1:0] fill;
  logic [FIELD_W-1:0] frame_length;

  modport source (output valid, output event_res, output byte_out, output write_addr,
                  output base_addr, output fill, output frame_length, input ready);
  modport sink   (input valid, input event_res, input byte_out, input write_addr,
                  input base_addr, input fill, input frame_length, output ready);
endinterface

`default_nettype wire

### hdl/meter_telegram_framer.sv
// Top level of the meter telegram framer: byte tracking, ring pointers and result register.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+-----------------------------------------
//   in_ch    | sink      | valid / ready    | rx_byte
//   out_ch   | source    | valid / ready    | event_res, byte_out, write_addr,
//            |           |                  | base_addr, fill, frame_length
//   APB      | slave     | psel / penable   | paddr, pwdata, prdata (checksum enable)
//
// One byte is taken per cycle unless a waiting result is held back by out_ch.ready; its
// result appears in the output register on the next cycle. The framing state is updated
// by the same combinational logic that loads the result register, so the pointer add and
// end-of-frame compare set the clock rate. A new byte is taken while a result waits, as
// long as that result leaves in the same cycle. Reset is synchronous and clears the
// pointers, trackers and output valid; checksum mode comes out of reset enabled.
`timescale 1ns / 1ps
`default_nettype none

module meter_telegram_framer #(
  parameter int RING_DEPTH = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  mtf_in_if.sink           in_ch,
  mtf_out_if.source        out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import mtf_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int EW = AW + 1;
  localparam logic [AW-1:0] DEPTH_M1 = AW'(RING_DEPTH - 1);

  // Adds two ring offsets and wraps modulo the ring depth.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(RING_DEPTH)) s = s - (AW+1)'(RING_DEPTH);
    return s[AW-1:0];
  endfunction

  // Fits an internal count to the fixed field width of the result word.
  function automatic logic [FIELD_W-1:0] to_field(input logic [AW-1:0] v);
    logic [FIELD_W+AW-1:0] t;
    t = {{FIELD_W{1'b0}}, v};
    return t[FIELD_W-1:0];
  endfunction

  // Framing state.
  logic          cksum_en_r;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] slash_r, slash_nxt;
  logic          bang_vld_r, bang_vld_nxt;
  logic [AW-1:0] bang_off_r, bang_off_nxt;
  logic [2:0]    hex_seen_r, hex_seen_nxt;
  logic          hex_fail_r, hex_fail_nxt;
  logic          post_cr_r, post_cr_nxt;
  logic          post_lf1_r, post_lf1_nxt;
  logic          post_lf2_r, post_lf2_nxt;

  // Result register.
  logic          out_vld_r, out_vld_nxt;
  event_t        ev_r, ev_nxt;
  logic [7:0]    byte_r;
  logic [AW-1:0] waddr_r, waddr_nxt;
  logic [AW-1:0] flen_r, flen_nxt;
  logic [AW-1:0] obase_r, ofill_r;

  logic          accept;
  logic [7:0]    c;
  logic          cfg_wr;

  // Intermediate values of the store path.
  logic [AW-1:0] p_fill1;
  logic [AW-1:0] p_slash;
  logic          p_bv;
  logic [AW-1:0] p_bo;
  logic [2:0]    p_hs;
  logic          p_hf, p_cr, p_lf1, p_lf2;
  logic [1:0]    p_extra;
  logic [EW-1:0] end_w, fill1_w;
  logic [AW-1:0] rest;
  logic          done;

  assign c      = in_ch.rx_byte;
  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  // Configuration port: single register, writes complete in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CHECKSUM_EN);
  assign prdata = (paddr[2] == REG_CHECKSUM_EN) ? {31'b0, cksum_en_r} : 32'b0;

  // Per-byte framing logic.
  always_comb begin
    base_nxt     = base_r;
    fill_nxt     = fill_r;
    slash_nxt    = slash_r;
    bang_vld_nxt = bang_vld_r;
    bang_off_nxt = bang_off_r;
    hex_seen_nxt = hex_seen_r;
    hex_fail_nxt = hex_fail_r;
    post_cr_nxt  = post_cr_r;
    post_lf1_nxt = post_lf1_r;
    post_lf2_nxt = post_lf2_r;
    ev_nxt       = EV_STORE;
    waddr_nxt    = '0;
    flen_nxt     = '0;

    // Store path, worked out regardless and used only when the byte is kept.
    p_fill1 = fill_r + AW'(1);
    p_slash = ((c == CHAR_SLASH) && (fill_r != '0)) ? fill_r : slash_r;
    p_bv    = bang_vld_r;
    p_bo    = bang_off_r;
    p_hs    = hex_seen_r;
    p_hf    = hex_fail_r;
    p_cr    = post_cr_r;
    p_lf1   = post_lf1_r;
    p_lf2   = post_lf2_r;
    if (c == CHAR_BANG) begin
      p_bv  = 1'b1;
      p_bo  = fill_r;
      p_hs  = '0;
      p_hf  = 1'b0;
      p_cr  = 1'b0;
      p_lf1 = 1'b0;
      p_lf2 = 1'b0;
    end else if (bang_vld_r) begin
      if ((hex_seen_r < 3'd4) && !is_hex(c)) p_hf = 1'b1;
      if (hex_seen_r == 3'd0) begin
        p_cr  = (c == CHAR_CR);
        p_lf1 = (c == CHAR_LF);
      end else if (hex_seen_r == 3'd1) begin
        p_lf2 = (c == CHAR_LF);
      end
      if (hex_seen_r != 3'd7) p_hs = hex_seen_r + 3'd1;
    end

    // Frame end: four digits after the '!' in checksum mode, else the frame ends at the '!' itself.
    p_extra = 2'd0;
    if ((p_hs >= 3'd1) && p_cr) begin
      p_extra = ((p_hs >= 3'd2) && p_lf2) ? 2'd2 : 2'd1;
    end else if ((p_hs >= 3'd1) && p_lf1) begin
      p_extra = 2'd1;
    end
    end_w   = {1'b0, p_bo} + EW'(1) + (cksum_en_r ? EW'(4) : EW'(p_extra));
    fill1_w = {1'b0, p_fill1};
    done    = p_bv && (cksum_en_r ? ((p_hs >= 3'd4) && !p_hf) : 1'b1) && (end_w <= fill1_w);
    rest    = AW'(fill1_w - end_w);

    priority if ((fill_r == '0) && (c != CHAR_SLASH)) begin
      ev_nxt = EV_DROP;
    end else if (fill_r >= DEPTH_M1) begin
      if ((slash_r != '0) && (slash_r < fill_r)) begin
        // Restart at the last slash; the incoming byte is discarded.
        ev_nxt    = EV_RESYNC;
        base_nxt  = ring_add(base_r, slash_r);
        fill_nxt  = fill_r - slash_r;
        slash_nxt = '0;
        if (bang_vld_r && (bang_off_r >= slash_r)) begin
          bang_off_nxt = bang_off_r - slash_r;
        end else begin
          bang_vld_nxt = 1'b0;
          bang_off_nxt = '0;
          hex_seen_nxt = '0;
          hex_fail_nxt = 1'b0;
          post_cr_nxt  = 1'b0;
          post_lf1_nxt = 1'b0;
          post_lf2_nxt = 1'b0;
        end
      end else begin
        // No slash to restart on, so the whole buffer goes.
        ev_nxt       = EV_OVF_DROP;
        fill_nxt     = '0;
        slash_nxt    = '0;
        bang_vld_nxt = 1'b0;
        bang_off_nxt = '0;
        hex_seen_nxt = '0;
        hex_fail_nxt = 1'b0;
        post_cr_nxt  = 1'b0;
        post_lf1_nxt = 1'b0;
        post_lf2_nxt = 1'b0;
      end
    end else begin
      waddr_nxt = ring_add(base_r, fill_r);
      if (done) begin
        // Release the completed frame and rebase what follows it.
        ev_nxt       = EV_DONE;
        base_nxt     = ring_add(base_r, end_w[AW-1:0]);
        fill_nxt     = rest;
        flen_nxt     = end_w[AW-1:0];
        slash_nxt    = ((rest != '0) && ({1'b0, p_slash} >= end_w)) ?
                       AW'({1'b0, p_slash} - end_w) : '0;
        bang_vld_nxt = 1'b0;
        bang_off_nxt = '0;
        hex_seen_nxt = '0;
        hex_fail_nxt = 1'b0;
        post_cr_nxt  = 1'b0;
        post_lf1_nxt = 1'b0;
        post_lf2_nxt = 1'b0;
      end else begin
        fill_nxt     = p_fill1;
        slash_nxt    = p_slash;
        bang_vld_nxt = p_bv;
        bang_off_nxt = p_bo;
        hex_seen_nxt = p_hs;
        hex_fail_nxt = p_hf;
        post_cr_nxt  = p_cr;
        post_lf1_nxt = p_lf1;
        post_lf2_nxt = p_lf2;
      end
    end
  end

  // Output valid follows accepts and departures.
  always_comb begin
    if (accept) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cksum_en_r <= 1'b1;
      out_vld_r  <= 1'b0;
      base_r     <= '0;
      fill_r     <= '0;
      slash_r    <= '0;
      bang_vld_r <= 1'b0;
      bang_off_r <= '0;
      hex_seen_r <= '0;
      hex_fail_r <= 1'b0;
      post_cr_r  <= 1'b0;
      post_lf1_r <= 1'b0;
      post_lf2_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (cfg_wr) cksum_en_r <= pwdata[0];
      if (accept) begin
        base_r     <= base_nxt;
        fill_r     <= fill_nxt;
        slash_r    <= slash_nxt;
        bang_vld_r <= bang_vld_nxt;
        bang_off_r <= bang_off_nxt;
        hex_seen_r <= hex_seen_nxt;
        hex_fail_r <= hex_fail_nxt;
        post_cr_r  <= post_cr_nxt;
        post_lf1_r <= post_lf1_nxt;
        post_lf2_r <= post_lf2_nxt;
      end
    end
  end

  // Result payload, loaded with each accepted byte.
  always_ff @(posedge clk) begin
    if (accept) begin
      ev_r    <= ev_nxt;
      byte_r  <= c;
      waddr_r <= waddr_nxt;
      flen_r  <= flen_nxt;
      obase_r <= base_nxt;
      ofill_r <= fill_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.event_res    = ev_r;
  assign out_ch.byte_out     = byte_r;
  assign out_ch.write_addr   = to_field(waddr_r);
  assign out_ch.base_addr    = to_field(obase_r);
  assign out_ch.fill         = to_field(ofill_r);
  assign out_ch.frame_length = to_field(flen_r);

  // An accepted byte always leaves a result waiting in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_vld_r)
    else $error("accepted byte produced no result");

  // The last '!' always lies inside the held bytes.
  a_bang_inside: assert property (@(posedge clk) disable iff (!rst_n)
    bang_vld_r |-> (bang_off_r < fill_r))
    else $error("bang offset beyond fill");

  // The resync slash is either absent or inside the held bytes.
  a_slash_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (slash_r == '0) || (slash_r < fill_r))
    else $error("slash offset beyond fill");

  // A dropped byte never touches the ring, so the buffer stays empty.
  a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (ev_r == EV_DROP)) |-> ((ofill_r == '0) && (waddr_r == '0)))
    else $error("dropped byte left bytes in the buffer");

endmodule

`default_nettype wire
